>>> rtl/cau_pkg.sv
`timescale 1ns / 1ps
// Package of the complex ALU: constants, word types and shared helper functions.
package cau_pkg;

  // Word format and pipeline geometry.
  localparam int WORD_BITS    = 32;
  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 24;
  localparam int PROD_W       = 2 * WORD_BITS;
  localparam int SUM_W        = PROD_W + 1;
  localparam int Q_W          = WORD_BITS + 1;
  localparam int HEAD_SH      = Q_W - FRAC_BITS;
  localparam int N_CELLS      = Q_W;
  localparam int IDX_W        = $clog2(N_CELLS);
  localparam int ANG_FRAC     = 30;
  localparam int ANG_SH       = ANG_FRAC - FRAC_BITS;
  localparam int XY_W         = WORD_BITS + 4;
  localparam int Z_W          = 36;
  localparam int ATAN_N       = 32;
  localparam int ATAN_IDX_W   = $clog2(ATAN_N);

  // Angle constants in Q2.30 and the rounded limit of the angle output.
  localparam logic signed [Z_W-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [Z_W-1:0] ANG_HALF    = Z_W'(longint'(1) << (ANG_SH - 1));
  localparam logic signed [Z_W-1:0] PI_FRAC     = (PI_Q30 + ANG_HALF) >>> ANG_SH;

  // Saturation limits.
  localparam logic signed [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS - 1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] W_MIN = {1'b1, {(WORD_BITS - 1){1'b0}}};
  localparam logic [PROD_W-1:0] MAG_MAX = {{(PROD_W - WORD_BITS + 1){1'b0}},
                                           {(WORD_BITS - 1){1'b1}}};
  localparam logic [PROD_W-1:0] MAG_MIN = MAG_MAX + PROD_W'(1);

  // Operation codes.
  localparam logic [2:0] MODE_ADD  = 3'd0;
  localparam logic [2:0] MODE_SUB  = 3'd1;
  localparam logic [2:0] MODE_MUL  = 3'd2;
  localparam logic [2:0] MODE_DIV  = 3'd3;
  localparam logic [2:0] MODE_CONJ = 3'd4;
  localparam logic [2:0] MODE_NEG  = 3'd5;
  localparam logic [2:0] MODE_ARG  = 3'd6;
  localparam logic [2:0] MODE_CMP  = 3'd7;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  // atan(2^-i) in Q2.30, rounded to nearest.
  localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
  };

  typedef struct packed {
    logic [2:0]                  mode;
    logic signed [WORD_BITS-1:0] a_re;
    logic signed [WORD_BITS-1:0] a_im;
    logic signed [WORD_BITS-1:0] b_re;
    logic signed [WORD_BITS-1:0] b_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] res_re;
    logic signed [WORD_BITS-1:0] res_im;
    logic                        is_equal;
    logic [1:0]                  status;
  } cau_out_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] val;
    logic                        sat;
  } cau_sat_t;

  // Word handed from cell to cell: finished results, divider and CORDIC state.
  typedef struct packed {
    logic [2:0]                  mode;
    logic signed [WORD_BITS-1:0] rr;
    logic signed [WORD_BITS-1:0] ri;
    logic                        eq;
    logic [1:0]                  st;
    logic [PROD_W-1:0]           d;
    logic [PROD_W-1:0]           rem_re;
    logic [PROD_W-1:0]           rem_im;
    logic [Q_W-1:0]              q_re;
    logic [Q_W-1:0]              q_im;
    logic [Q_W-1:0]              nb_re;
    logic [Q_W-1:0]              nb_im;
    logic                        ovf_re;
    logic                        ovf_im;
    logic                        neg_re;
    logic                        neg_im;
    logic                        dz;
    logic                        az;
    logic                        rot;
    logic signed [XY_W-1:0]      x;
    logic signed [XY_W-1:0]      y;
    logic signed [Z_W-1:0]       z;
  } cau_cell_t;

  // Saturates a value one bit wider than the word.
  function automatic cau_sat_t sat_wide(input logic signed [WORD_BITS:0] v);
    cau_sat_t r;
    r.sat = (v[WORD_BITS] != v[WORD_BITS-1]);
    if (!r.sat) begin
      r.val = v[WORD_BITS-1:0];
    end else if (v[WORD_BITS]) begin
      r.val = W_MIN;
    end else begin
      r.val = W_MAX;
    end
    return r;
  endfunction

  // Builds a saturated word from sign and magnitude.
  function automatic cau_sat_t from_smag(input logic neg, input logic [PROD_W-1:0] mag);
    cau_sat_t r;
    if (!neg) begin
      r.sat = (mag > MAG_MAX);
      r.val = r.sat ? W_MAX : mag[WORD_BITS-1:0];
    end else begin
      r.sat = (mag > MAG_MIN);
      r.val = r.sat ? W_MIN : WORD_BITS'(-mag);
    end
    return r;
  endfunction

  // Angle step of one CORDIC iteration.
  function automatic logic [31:0] atan_q30(input logic [IDX_W-1:0] k);
    logic [31:0] r;
    r = '0;
    if (k < IDX_W'(ATAN_N)) begin
      r = ATAN_TAB[k[ATAN_IDX_W-1:0]];
    end
    return r;
  endfunction

endpackage

>>> rtl/cau_front.sv
`timescale 1ns / 1ps
// Front end of the complex ALU: products, sums, simple operations and cell setup.
module cau_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  cau_pkg::cau_in_t    in_word,
  output logic                cell_valid,
  output cau_pkg::cau_cell_t  cell_word
);

  localparam int WW = cau_pkg::WORD_BITS;
  localparam int PW = cau_pkg::PROD_W;
  localparam int SW = cau_pkg::SUM_W;
  localparam int XW = cau_pkg::XY_W;
  localparam int FB = cau_pkg::FRAC_BITS;
  localparam int HS = cau_pkg::HEAD_SH;

  // First stage: the six products and the simple operations.
  logic                   v1_r;
  logic [2:0]             mode1_r;
  logic signed [WW-1:0]   are1_r, aim1_r;
  logic signed [PW-1:0]   p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_bbr_r, p_bbi_r;
  logic signed [WW-1:0]   rr1_r, ri1_r, rr1_nxt, ri1_nxt;
  logic                   eq1_r, eq1_nxt, dz1_r, az1_r;
  logic [1:0]             st1_r, st1_nxt;
  logic signed [WW:0]     are_x, aim_x, bre_x, bim_x;
  cau_pkg::cau_sat_t      add_re, add_im, sub_re, sub_im, ngt_re, ngt_im;

  always_comb begin
    are_x  = (WW + 1)'(in_word.a_re);
    aim_x  = (WW + 1)'(in_word.a_im);
    bre_x  = (WW + 1)'(in_word.b_re);
    bim_x  = (WW + 1)'(in_word.b_im);
    add_re = cau_pkg::sat_wide(are_x + bre_x);
    add_im = cau_pkg::sat_wide(aim_x + bim_x);
    sub_re = cau_pkg::sat_wide(are_x - bre_x);
    sub_im = cau_pkg::sat_wide(aim_x - bim_x);
    ngt_re = cau_pkg::sat_wide(-are_x);
    ngt_im = cau_pkg::sat_wide(-aim_x);
    rr1_nxt = '0;
    ri1_nxt = '0;
    eq1_nxt = 1'b0;
    st1_nxt = cau_pkg::ST_OK;
    case (in_word.mode)
      cau_pkg::MODE_ADD: begin
        rr1_nxt = add_re.val;
        ri1_nxt = add_im.val;
        st1_nxt = (add_re.sat || add_im.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
      cau_pkg::MODE_SUB: begin
        rr1_nxt = sub_re.val;
        ri1_nxt = sub_im.val;
        st1_nxt = (sub_re.sat || sub_im.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
      cau_pkg::MODE_CONJ: begin
        rr1_nxt = in_word.a_re;
        ri1_nxt = ngt_im.val;
        st1_nxt = ngt_im.sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
      cau_pkg::MODE_NEG: begin
        rr1_nxt = ngt_re.val;
        ri1_nxt = ngt_im.val;
        st1_nxt = (ngt_re.sat || ngt_im.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
      cau_pkg::MODE_CMP: begin
        eq1_nxt = (in_word.a_re == in_word.b_re) && (in_word.a_im == in_word.b_im);
      end
      default: begin
        rr1_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode1_r <= in_word.mode;
      are1_r  <= in_word.a_re;
      aim1_r  <= in_word.a_im;
      p_rr_r  <= PW'(in_word.a_re) * PW'(in_word.b_re);
      p_ii_r  <= PW'(in_word.a_im) * PW'(in_word.b_im);
      p_ri_r  <= PW'(in_word.a_re) * PW'(in_word.b_im);
      p_ir_r  <= PW'(in_word.a_im) * PW'(in_word.b_re);
      p_bbr_r <= PW'(in_word.b_re) * PW'(in_word.b_re);
      p_bbi_r <= PW'(in_word.b_im) * PW'(in_word.b_im);
      rr1_r   <= rr1_nxt;
      ri1_r   <= ri1_nxt;
      eq1_r   <= eq1_nxt;
      st1_r   <= st1_nxt;
      dz1_r   <= (in_word.b_re == '0) && (in_word.b_im == '0);
      az1_r   <= (in_word.a_re == '0) && (in_word.a_im == '0);
    end
  end

  // Second stage: product sums and the divisor.
  logic                   v2_r;
  logic [2:0]             mode2_r;
  logic signed [WW-1:0]   are2_r, aim2_r, rr2_r, ri2_r;
  logic                   eq2_r, dz2_r, az2_r;
  logic [1:0]             st2_r;
  logic signed [SW-1:0]   mul_re2_r, mul_im2_r, num_re2_r, num_im2_r;
  logic [PW-1:0]          d2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode2_r   <= mode1_r;
      are2_r    <= are1_r;
      aim2_r    <= aim1_r;
      rr2_r     <= rr1_r;
      ri2_r     <= ri1_r;
      eq2_r     <= eq1_r;
      st2_r     <= st1_r;
      dz2_r     <= dz1_r;
      az2_r     <= az1_r;
      mul_re2_r <= SW'(p_rr_r) - SW'(p_ii_r);
      mul_im2_r <= SW'(p_ri_r) + SW'(p_ir_r);
      num_re2_r <= SW'(p_rr_r) + SW'(p_ii_r);
      num_im2_r <= SW'(p_ir_r) - SW'(p_ri_r);
      d2_r      <= p_bbr_r + p_bbi_r;
    end
  end

  // Third stage: product magnitudes, divider and CORDIC start values.
  logic                   cell_valid_r;
  cau_pkg::cau_cell_t     cell_r, cell_nxt;
  logic [SW-1:0]          mul_mag_re, mul_mag_im, num_mag_re, num_mag_im;
  cau_pkg::cau_sat_t      mul_re, mul_im;

  always_comb begin
    mul_mag_re = mul_re2_r[SW-1] ? SW'(-mul_re2_r) : SW'(mul_re2_r);
    mul_mag_im = mul_im2_r[SW-1] ? SW'(-mul_im2_r) : SW'(mul_im2_r);
    num_mag_re = num_re2_r[SW-1] ? SW'(-num_re2_r) : SW'(num_re2_r);
    num_mag_im = num_im2_r[SW-1] ? SW'(-num_im2_r) : SW'(num_im2_r);
    mul_re = cau_pkg::from_smag(mul_re2_r[SW-1], PW'(mul_mag_re >> FB));
    mul_im = cau_pkg::from_smag(mul_im2_r[SW-1], PW'(mul_mag_im >> FB));

    cell_nxt.mode = mode2_r;
    cell_nxt.rr   = rr2_r;
    cell_nxt.ri   = ri2_r;
    cell_nxt.eq   = eq2_r;
    cell_nxt.st   = st2_r;
    if (mode2_r == cau_pkg::MODE_MUL) begin
      cell_nxt.rr = mul_re.val;
      cell_nxt.ri = mul_im.val;
      cell_nxt.st = (mul_re.sat || mul_im.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end

    // Division starts with the quotient head already known to be zero.
    cell_nxt.d      = d2_r;
    cell_nxt.rem_re = num_mag_re[PW-1:0] >> HS;
    cell_nxt.rem_im = num_mag_im[PW-1:0] >> HS;
    cell_nxt.nb_re  = {num_mag_re[HS-1:0], {FB{1'b0}}};
    cell_nxt.nb_im  = {num_mag_im[HS-1:0], {FB{1'b0}}};
    cell_nxt.q_re   = '0;
    cell_nxt.q_im   = '0;
    cell_nxt.ovf_re = 1'b0;
    cell_nxt.ovf_im = 1'b0;
    cell_nxt.neg_re = num_re2_r[SW-1];
    cell_nxt.neg_im = num_im2_r[SW-1];
    cell_nxt.dz     = dz2_r;
    cell_nxt.az     = az2_r;

    // Axis angles are exact; others rotate from the right half plane.
    cell_nxt.rot = 1'b0;
    cell_nxt.x   = '0;
    cell_nxt.y   = '0;
    cell_nxt.z   = '0;
    if (aim2_r == '0) begin
      cell_nxt.z = (are2_r > 0) ? '0 : cau_pkg::PI_Q30;
    end else if (are2_r == '0) begin
      cell_nxt.z = (aim2_r > 0) ? cau_pkg::HALF_PI_Q30 : -cau_pkg::HALF_PI_Q30;
    end else begin
      cell_nxt.rot = 1'b1;
      if (are2_r < 0) begin
        cell_nxt.x = -XW'(are2_r);
        cell_nxt.y = -XW'(aim2_r);
        cell_nxt.z = (aim2_r > 0) ? cau_pkg::PI_Q30 : -cau_pkg::PI_Q30;
      end else begin
        cell_nxt.x = XW'(are2_r);
        cell_nxt.y = XW'(aim2_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_valid_r <= 1'b0;
    end else if (en) begin
      cell_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_valid = cell_valid_r;
  assign cell_word  = cell_r;

endmodule

>>> rtl/cau_cell.sv
`timescale 1ns / 1ps
// One cell of the chain: a quotient bit for each part and, below CORDIC_STEPS, one CORDIC rotation.
module cau_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic [cau_pkg::IDX_W-1:0]  idx,
  input  logic                       in_valid,
  input  cau_pkg::cau_cell_t         in_cell,
  output logic                       out_valid,
  output cau_pkg::cau_cell_t         out_cell
);

  localparam int PW = cau_pkg::PROD_W;
  localparam int QW = cau_pkg::Q_W;
  localparam int ZW = cau_pkg::Z_W;
  localparam int IW = cau_pkg::IDX_W;

  logic                  valid_r;
  cau_pkg::cau_cell_t    cell_r, cell_nxt;
  logic [PW:0]           r2_re, r2_im, d_x;
  logic                  ge_re, ge_im;
  logic signed [cau_pkg::XY_W-1:0] dx, dy;
  logic signed [ZW-1:0]  ang;

  always_comb begin
    cell_nxt = in_cell;

    // Restoring division step on both numerators against the shared divisor.
    d_x   = {1'b0, in_cell.d};
    r2_re = {in_cell.rem_re, in_cell.nb_re[QW-1]};
    r2_im = {in_cell.rem_im, in_cell.nb_im[QW-1]};
    ge_re = (r2_re >= d_x);
    ge_im = (r2_im >= d_x);
    cell_nxt.rem_re = ge_re ? PW'(r2_re - d_x) : r2_re[PW-1:0];
    cell_nxt.rem_im = ge_im ? PW'(r2_im - d_x) : r2_im[PW-1:0];
    cell_nxt.q_re   = {in_cell.q_re[QW-2:0], ge_re};
    cell_nxt.q_im   = {in_cell.q_im[QW-2:0], ge_im};
    cell_nxt.nb_re  = in_cell.nb_re << 1;
    cell_nxt.nb_im  = in_cell.nb_im << 1;
    // A remainder at or above the divisor means the quotient exceeds the word.
    cell_nxt.ovf_re = in_cell.ovf_re || (in_cell.rem_re >= in_cell.d);
    cell_nxt.ovf_im = in_cell.ovf_im || (in_cell.rem_im >= in_cell.d);

    // Vectoring CORDIC rotation toward the positive real axis.
    dx  = in_cell.y >>> idx;
    dy  = in_cell.x >>> idx;
    ang = ZW'(cau_pkg::atan_q30(idx));
    if (in_cell.rot && (idx < IW'(cau_pkg::CORDIC_STEPS))) begin
      if (in_cell.y > 0) begin
        cell_nxt.x = in_cell.x + dx;
        cell_nxt.y = in_cell.y - dy;
        cell_nxt.z = in_cell.z + ang;
      end else begin
        cell_nxt.x = in_cell.x - dx;
        cell_nxt.y = in_cell.y + dy;
        cell_nxt.z = in_cell.z - ang;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_cell  = cell_r;

endmodule

>>> rtl/cau_back.sv
`timescale 1ns / 1ps
// Back end of the complex ALU: quotient and angle formatting and the output register.
module cau_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  cau_pkg::cau_cell_t  in_cell,
  output logic                out_valid,
  output cau_pkg::cau_out_t   out_word
);

  localparam int WW = cau_pkg::WORD_BITS;
  localparam int PW = cau_pkg::PROD_W;
  localparam int ZW = cau_pkg::Z_W;

  logic                  out_valid_r;
  cau_pkg::cau_out_t     out_word_r, out_word_nxt;
  logic [2:0]            mode_r;
  cau_pkg::cau_sat_t     div_re, div_im;
  logic signed [ZW-1:0]  z_sum, z_rnd;

  // Final result per operation.
  always_comb begin
    div_re = cau_pkg::from_smag(in_cell.neg_re,
                                in_cell.ovf_re ? {PW{1'b1}} : PW'(in_cell.q_re));
    div_im = cau_pkg::from_smag(in_cell.neg_im,
                                in_cell.ovf_im ? {PW{1'b1}} : PW'(in_cell.q_im));
    z_sum = in_cell.z + cau_pkg::ANG_HALF;
    z_rnd = z_sum >>> cau_pkg::ANG_SH;
    if (z_rnd > cau_pkg::PI_FRAC) begin
      z_rnd = cau_pkg::PI_FRAC;
    end else if (z_rnd <= -cau_pkg::PI_FRAC) begin
      z_rnd = -cau_pkg::PI_FRAC + ZW'(1);
    end

    out_word_nxt.res_re   = in_cell.rr;
    out_word_nxt.res_im   = in_cell.ri;
    out_word_nxt.is_equal = in_cell.eq;
    out_word_nxt.status   = in_cell.st;
    case (in_cell.mode)
      cau_pkg::MODE_DIV: begin
        if (in_cell.dz) begin
          out_word_nxt.res_re = '0;
          out_word_nxt.res_im = '0;
          out_word_nxt.status = cau_pkg::ST_ZERO;
        end else begin
          out_word_nxt.res_re = div_re.val;
          out_word_nxt.res_im = div_im.val;
          out_word_nxt.status = (div_re.sat || div_im.sat) ? cau_pkg::ST_SAT
                                                            : cau_pkg::ST_OK;
        end
      end
      cau_pkg::MODE_ARG: begin
        out_word_nxt.res_im = '0;
        if (in_cell.az) begin
          out_word_nxt.res_re = '0;
          out_word_nxt.status = cau_pkg::ST_ZERO;
        end else begin
          out_word_nxt.res_re = WW'(z_rnd);
          out_word_nxt.status = cau_pkg::ST_OK;
        end
      end
      default: begin
        out_word_nxt.status = in_cell.st;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word_r <= out_word_nxt;
      mode_r     <= in_cell.mode;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // The zero-operand status comes only from divide or argument.
  a_zero_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.status == cau_pkg::ST_ZERO) |->
      (mode_r == cau_pkg::MODE_DIV || mode_r == cau_pkg::MODE_ARG))
    else $error("zero status outside divide or argument");

  // Equality is reported only by compare.
  a_equal_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.is_equal) |-> (mode_r == cau_pkg::MODE_CMP))
    else $error("equality flag outside compare");

  // The angle stays within (-pi, pi] and has no imaginary part.
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && mode_r == cau_pkg::MODE_ARG) |->
      (out_word_r.res_im == '0 &&
       ZW'(out_word_r.res_re) <= cau_pkg::PI_FRAC &&
       ZW'(out_word_r.res_re) > -cau_pkg::PI_FRAC))
    else $error("angle out of range");

endmodule

>>> rtl/complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// Top level of the complex ALU: front end, chain of cells and output register.
//
// Complex-number ALU in signed Q16.16: add, subtract, multiply, divide, conjugate,
// negate, argument (CORDIC atan2, radians in (-pi, pi]) and compare. It takes one
// word per cycle and returns one result word for each, in order, after three front-end
// stages (products, sums, magnitudes), a chain of 33 cells that each settle one
// quotient bit of the division and, below CORDIC_STEPS, one CORDIC rotation, and the
// output register. The divider's 33 quotient bits set the chain length. While a
// result word is held by out_stall the whole pipeline holds and in_stall is high.
module complex_arithmetic_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cau_pkg::cau_in_t   in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output cau_pkg::cau_out_t  out_word
);

  localparam int NC = cau_pkg::N_CELLS;
  localparam int IW = cau_pkg::IDX_W;

  // The pipeline moves whenever the output register is free or being taken.
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  logic [NC:0]           chain_valid;
  cau_pkg::cau_cell_t    chain_word [NC+1];

  cau_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .in_valid   (in_valid),
    .in_word    (in_word),
    .cell_valid (chain_valid[0]),
    .cell_word  (chain_word[0])
  );

  // Chain of cells.
  for (genvar i = 0; i < NC; i++) begin : g_cell
    cau_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .idx       (IW'(i)),
      .in_valid  (chain_valid[i]),
      .in_cell   (chain_word[i]),
      .out_valid (chain_valid[i+1]),
      .out_cell  (chain_word[i+1])
    );
  end

  cau_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (chain_valid[NC]),
    .in_cell   (chain_word[NC]),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

>>> tb/complex_arithmetic_unit_tb.sv
`timescale 1ns / 1ps
// Testbench of the complex ALU: random and directed words checked against a local predictor.
module complex_arithmetic_unit_tb;

  // Expected results of the complex ALU, one per accepted operand word.
  class cau_scoreboard;
    cau_pkg::cau_out_t result_q[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    // Saturates a wide signed value to the word and flags saturation.
    function logic [31:0] clip(input logic signed [97:0] v, inout logic [1:0] st);
      if (v > 98'sd2147483647) begin
        st = cau_pkg::ST_SAT;
        return cau_pkg::W_MAX;
      end
      if (v < -98'sd2147483648) begin
        st = cau_pkg::ST_SAT;
        return cau_pkg::W_MIN;
      end
      return v[31:0];
    endfunction

    // Angle of a nonzero point in Q16.16, atan2 quadrant rules.
    function longint angle(input longint re, input longint im);
      longint z, x, y, off, dx, dy, pif, tab;
      int k;
      x = re;
      y = im;
      off = 0;
      if (im == 0) begin
        z = (re > 0) ? 0 : longint'(cau_pkg::PI_Q30);
      end else if (re == 0) begin
        z = (im > 0) ? longint'(cau_pkg::HALF_PI_Q30) : -longint'(cau_pkg::HALF_PI_Q30);
      end else begin
        // Fold the left half plane onto the right and add pi back at the end.
        if (x < 0) begin
          x = -x;
          y = -y;
          off = (im > 0) ? longint'(cau_pkg::PI_Q30) : -longint'(cau_pkg::PI_Q30);
        end
        z = 0;
        for (k = 0; k < cau_pkg::CORDIC_STEPS; k++) begin
          tab = longint'(cau_pkg::ATAN_TAB[k & 31]);
          dx = y >>> (k & 31);
          dy = x >>> (k & 31);
          if (y > 0) begin
            x = x + dx;
            y = y - dy;
            z = z + tab;
          end else begin
            x = x - dx;
            y = y + dy;
            z = z - tab;
          end
        end
        z = z + off;
      end
      z = (z + (longint'(1) << 13)) >>> 14;
      pif = (longint'(cau_pkg::PI_Q30) + (longint'(1) << 13)) >>> 14;
      if (z > pif) z = pif;
      if (z <= -pif) z = -pif + 1;
      return z;
    endfunction

    // Sign and magnitude to a saturated word.
    function logic [31:0] pack_mag(input logic neg, input logic [97:0] mag,
                                   inout logic [1:0] st);
      logic signed [97:0] v;
      v = neg ? -$signed(mag) : $signed(mag);
      return clip(v, st);
    endfunction

    function cau_pkg::cau_out_t predict(input cau_pkg::cau_in_t w);
      cau_pkg::cau_out_t r;
      logic signed [97:0] ar, ai, br, bi, pr, pim, d;
      logic [97:0] mr, mi, qr, qi;
      logic [1:0] st;
      ar = w.a_re;
      ai = w.a_im;
      br = w.b_re;
      bi = w.b_im;
      st = cau_pkg::ST_OK;
      r = '0;
      case (w.mode)
        cau_pkg::MODE_ADD: begin
          r.res_re = clip(ar + br, st);
          r.res_im = clip(ai + bi, st);
        end
        cau_pkg::MODE_SUB: begin
          r.res_re = clip(ar - br, st);
          r.res_im = clip(ai - bi, st);
        end
        cau_pkg::MODE_MUL: begin
          // Magnitudes are truncated, so rounding is toward zero.
          pr = ar * br - ai * bi;
          pim = ar * bi + ai * br;
          mr = (pr < 0) ? -pr : pr;
          mi = (pim < 0) ? -pim : pim;
          r.res_re = pack_mag(pr < 0, mr >> cau_pkg::FRAC_BITS, st);
          r.res_im = pack_mag(pim < 0, mi >> cau_pkg::FRAC_BITS, st);
        end
        cau_pkg::MODE_DIV: begin
          d = br * br + bi * bi;
          if (d == 0) begin
            st = cau_pkg::ST_ZERO;
          end else begin
            pr = ar * br + ai * bi;
            pim = ai * br - ar * bi;
            mr = (pr < 0) ? -pr : pr;
            mi = (pim < 0) ? -pim : pim;
            qr = (mr << cau_pkg::FRAC_BITS) / d;
            qi = (mi << cau_pkg::FRAC_BITS) / d;
            if (qr > 98'h1_0000_0000) qr = 98'h1_0000_0000;
            if (qi > 98'h1_0000_0000) qi = 98'h1_0000_0000;
            r.res_re = pack_mag(pr < 0, qr, st);
            r.res_im = pack_mag(pim < 0, qi, st);
          end
        end
        cau_pkg::MODE_CONJ: begin
          r.res_re = w.a_re;
          r.res_im = clip(-ai, st);
        end
        cau_pkg::MODE_NEG: begin
          r.res_re = clip(-ar, st);
          r.res_im = clip(-ai, st);
        end
        cau_pkg::MODE_ARG: begin
          if (ar == 0 && ai == 0) st = cau_pkg::ST_ZERO;
          else r.res_re = clip(98'(angle(longint'(ar), longint'(ai))), st);
        end
        default: begin
          r.is_equal = (ar == br) && (ai == bi);
        end
      endcase
      r.status = st;
      return r;
    endfunction

    function void note(input cau_pkg::cau_in_t w);
      result_q.push_back(predict(w));
    endfunction

    function void check(input cau_pkg::cau_out_t got);
      cau_pkg::cau_out_t exp_r;
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        errors++;
        return;
      end
      exp_r = result_q.pop_front();
      if (got.res_re !== exp_r.res_re) begin
        $display("%0t: res_re expected %h actual %h", $time, exp_r.res_re, got.res_re);
        errors++;
      end
      if (got.res_im !== exp_r.res_im) begin
        $display("%0t: res_im expected %h actual %h", $time, exp_r.res_im, got.res_im);
        errors++;
      end
      if (got.is_equal !== exp_r.is_equal) begin
        $display("%0t: is_equal expected %b actual %b", $time, exp_r.is_equal, got.is_equal);
        errors++;
      end
      if (got.status !== exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  cau_pkg::cau_in_t  in_word;
  logic              out_valid;
  logic              out_stall;
  cau_pkg::cau_out_t out_word;

  cau_scoreboard sb;
  int  send_idle_pct;
  int  recv_idle_pct;
  int  hold_left;
  bit  hold_req;
  int  quiet_cycles;

  complex_arithmetic_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Receiver: checks results, stalls at random, and honors a long hold-off request.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check(out_word);
      if (hold_req && hold_left == 0) hold_left <= 300;
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
        if (hold_left == 1) hold_req <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= 3000) begin
        $display("complex_arithmetic_unit test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offers one word, with a random idle gap first, and waits for its acceptance.
  task automatic send_word(input cau_pkg::cau_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_word  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note(w);
  endtask

  task automatic send_op(input logic [2:0] m, input logic [31:0] ar, input logic [31:0] ai,
                         input logic [31:0] br, input logic [31:0] bi);
    cau_pkg::cau_in_t w;
    w.mode = m;
    w.a_re = ar;
    w.a_im = ai;
    w.b_re = br;
    w.b_im = bi;
    send_word(w);
  endtask

  // Operand value: full range, small, shifted magnitude or a corner value.
  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    case ($urandom_range(5))
      0, 1: v = $urandom;
      2: v = $urandom_range(2097152) - 32'd1048576;
      3: begin
        case ($urandom_range(5))
          0: v = 32'h0;
          1: v = cau_pkg::W_MIN;
          2: v = cau_pkg::W_MAX;
          3: v = 32'h1_0000;
          4: v = 32'hffff_ffff;
          default: v = 32'h1;
        endcase
      end
      default: begin
        v = $urandom >> $urandom_range(31);
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  task automatic send_random();
    cau_pkg::cau_in_t w;
    w.mode = 3'($urandom_range(7));
    w.a_re = pick_operand();
    w.a_im = pick_operand();
    w.b_re = pick_operand();
    w.b_im = pick_operand();
    // Compare needs equal operands often enough to see both answers.
    if (w.mode == cau_pkg::MODE_CMP && $urandom_range(1)) begin
      w.b_re = w.a_re;
      if ($urandom_range(3) != 0) w.b_im = w.a_im;
    end
    send_word(w);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.result_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int n;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    out_stall = 1'b0;
    hold_left = 0;
    hold_req = 1'b0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: every operation, field extremes and the special cases.
    send_op(cau_pkg::MODE_ADD, cau_pkg::W_MAX, cau_pkg::W_MIN, 32'h1, 32'hffff_ffff);
    send_op(cau_pkg::MODE_ADD, 32'h1_0000, 32'h2_8000, 32'hffff_0000, 32'h0);
    send_op(cau_pkg::MODE_SUB, cau_pkg::W_MIN, cau_pkg::W_MAX, 32'h1, 32'hffff_ffff);
    send_op(cau_pkg::MODE_SUB, 32'h3_0000, 32'h0, 32'h1_0000, 32'h8000);
    send_op(cau_pkg::MODE_MUL, 32'h2_0000, 32'h3_0000, 32'h4_0000, 32'hffff_0000);
    send_op(cau_pkg::MODE_MUL, cau_pkg::W_MAX, cau_pkg::W_MAX, cau_pkg::W_MIN,
            cau_pkg::W_MIN);
    send_op(cau_pkg::MODE_MUL, cau_pkg::W_MIN, cau_pkg::W_MIN, cau_pkg::W_MIN,
            cau_pkg::W_MAX);
    send_op(cau_pkg::MODE_DIV, 32'h1_0000, 32'h1_0000, 32'h0, 32'h0);
    send_op(cau_pkg::MODE_DIV, 32'h4_0000, 32'h2_0000, 32'h0, 32'h2_0000);
    send_op(cau_pkg::MODE_DIV, cau_pkg::W_MAX, cau_pkg::W_MIN, 32'h0, 32'h1);
    send_op(cau_pkg::MODE_DIV, cau_pkg::W_MIN, cau_pkg::W_MIN, cau_pkg::W_MIN,
            cau_pkg::W_MIN);
    send_op(cau_pkg::MODE_CONJ, cau_pkg::W_MIN, cau_pkg::W_MIN, 32'h0, 32'h0);
    send_op(cau_pkg::MODE_CONJ, 32'h1_2345, cau_pkg::W_MAX, 32'h0, 32'h0);
    send_op(cau_pkg::MODE_NEG, cau_pkg::W_MIN, 32'h1, 32'h0, 32'h0);
    send_op(cau_pkg::MODE_NEG, cau_pkg::W_MAX, cau_pkg::W_MIN, 32'h0, 32'h0);
    send_op(cau_pkg::MODE_ARG, 32'h0, 32'h0, 32'h0, 32'h0);
    send_op(cau_pkg::MODE_ARG, 32'h1_0000, 32'h0, 32'h0, 32'h0);
    send_op(cau_pkg::MODE_ARG, cau_pkg::W_MIN, 32'h0, 32'h0, 32'h0);
    send_op(cau_pkg::MODE_ARG, 32'h0, 32'h5, 32'h0, 32'h0);
    send_op(cau_pkg::MODE_ARG, 32'h0, cau_pkg::W_MIN, 32'h0, 32'h0);
    send_op(cau_pkg::MODE_ARG, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'h0);
    send_op(cau_pkg::MODE_ARG, cau_pkg::W_MIN, 32'h1, 32'h0, 32'h0);
    send_op(cau_pkg::MODE_ARG, cau_pkg::W_MIN, 32'hffff_ffff, 32'h0, 32'h0);
    send_op(cau_pkg::MODE_CMP, cau_pkg::W_MIN, cau_pkg::W_MAX, cau_pkg::W_MIN,
            cau_pkg::W_MAX);
    send_op(cau_pkg::MODE_CMP, cau_pkg::W_MIN, cau_pkg::W_MAX, cau_pkg::W_MIN,
            cau_pkg::W_MIN);

    // Phase one: sender idles a quarter of the time, receiver most of it.
    send_idle_pct = 25;
    recv_idle_pct = 62;
    for (n = 0; n < 450; n++) send_random();
    wait_drained();

    // Phase two: roles swapped, with a long receiver hold-off early on.
    send_idle_pct = 62;
    recv_idle_pct = 25;
    hold_req <= 1'b1;
    for (n = 0; n < 450; n++) send_random();

    // Phase three: no random idling on either side, and another long receiver hold-off.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req <= 1'b1;
    for (n = 0; n < 450; n++) send_random();

    wait_drained();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.result_q.size() == 0) begin
      $display("complex_arithmetic_unit test passed");
    end else begin
      $display("complex_arithmetic_unit test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_cell.sv
rtl/cau_back.sv
rtl/complex_arithmetic_unit.sv
tb/complex_arithmetic_unit_tb.sv
